[hdl/kts_pkg.sv]
// Shared types, codes and constants of the keyframe track sampler.
package kts_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int TIME_W       = 32;
    localparam int VAL_W        = 32;
    localparam int SEG_W        = 6;
    localparam int FAC_W        = 18;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;

    // factor limits, signed Q2.16
    localparam logic signed [FAC_W-1:0] FAC_MIN = -18'sd65536;
    localparam logic signed [FAC_W-1:0] FAC_MAX = 18'sd131071;

    // item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOPING   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic [SEG_W-1:0]        key_index;
        logic [TIME_W-1:0]       time_value;
        logic signed [VAL_W-1:0] value_x;
        logic signed [VAL_W-1:0] value_y;
        logic signed [VAL_W-1:0] value_z;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_x;
        logic signed [VAL_W-1:0] out_y;
        logic signed [VAL_W-1:0] out_z;
        logic [SEG_W-1:0]        segment;
        logic                    segment_found;
    } t_res;

    // one stored keyframe
    typedef struct packed {
        logic [TIME_W-1:0]       time_value;
        logic signed [VAL_W-1:0] val_x;
        logic signed [VAL_W-1:0] val_y;
        logic signed [VAL_W-1:0] val_z;
    } t_key;

    // key write broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [SEG_W-1:0] idx;
        t_key             key;
    } t_wr;

    // search token handed from cell to cell
    typedef struct packed {
        logic             vld;
        logic             found;
        logic [SEG_W-1:0] seg;
        t_key             lk;
        t_key             rk;
    } t_tok;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SETUP,
        ST_DIV,
        ST_MIX
    } t_state;

endpackage

[hdl/kts_cell.sv]
// One key cell: stores a keyframe and checks the passing search token.
module kts_cell
    import kts_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int USED_W   = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_wr               i_wr,
    input  logic [TIME_W-1:0] i_qtime,
    input  logic [USED_W-1:0] i_used,
    input  t_key              i_prev_key,
    input  t_tok              i_tok,
    output t_key              o_key,
    output t_tok              o_tok
);

    t_key r_key;
    t_tok r_tok;
    t_tok n_tok;
    logic hit;

    // key storage, written by index match
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (32'(i_wr.idx) == 32'(CELL_IDX))) begin
            r_key <= i_wr.key;
        end
    end

    // this cell is the right key of segment CELL_IDX-1
    always_comb begin
        hit = (CELL_IDX >= 1) && (32'(i_used) > 32'(CELL_IDX))
              && (i_qtime <= r_key.time_value);
        n_tok = i_tok;
        if (i_tok.vld && !i_tok.found && hit) begin
            n_tok.found = 1'b1;
            n_tok.seg   = SEG_W'(CELL_IDX - 1);
            n_tok.lk    = i_prev_key;
            n_tok.rk    = r_key;
        end
    end

    // token stage: control is reset, payload is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld   <= 1'b0;
            r_tok.found <= 1'b0;
        end else begin
            r_tok.vld   <= n_tok.vld;
            r_tok.found <= n_tok.found;
        end
        r_tok.seg <= n_tok.seg;
        r_tok.lk  <= n_tok.lk;
        r_tok.rk  <= n_tok.rk;
    end

    assign o_key = r_key;
    assign o_tok = r_tok;

endmodule

[hdl/keyframe_track_sampler.sv]
// Top level: command port, key cell chain, factor divider and component mixer.
// Write item: result strobe in the cycle after the transfer; busy stays low.
// Sample item: the search token walks the cell chain from the launch register through
// every cell register; no match gives the result strobe after the walk, a match
// adds setup, 18 divider steps or none, and a multiply and a mix phase per component.
// One item at a time, the next taken once busy falls; no receiver stall. Reset: control, config.
module keyframe_track_sampler
    import kts_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    output logic                  o_res_vld,
    output t_res                  o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int USED_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int REM_W  = TIME_W + 1 + 16;
    localparam int PROD_W = VAL_W + 1 + FAC_W;
    localparam int SUM_W  = PROD_W - 16 + 1;

    t_state r_state, n_state;

    logic                  r_looping;
    logic [CFG_DATA_W-1:0] r_key_count;
    logic [TIME_W-1:0]     r_t;
    logic [USED_W-1:0]     r_used;
    logic                  r_launch;
    logic [SEG_W-1:0]      r_seg;
    t_key                  r_lk, r_rk;
    logic                  r_neg;
    logic [REM_W-1:0]      r_rem;
    logic [REM_W:0]        r_dsh;
    logic [FAC_W-1:0]      r_q;
    logic [4:0]            r_step;
    logic signed [FAC_W-1:0] r_f;
    logic [1:0]            r_comp;
    logic                  r_phase;
    logic signed [PROD_W-1:0] r_prod;
    t_res                  r_res;
    logic                  r_res_vld;

    t_wr  wr;
    t_key keys [MAX_KEYS];
    t_tok toks [MAX_KEYS+1];
    logic acc_cmd;

    // ------------------------------------------------------------------
    // config port
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_looping   <= 1'b0;
            r_key_count <= CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_idx)
                CFG_LOOPING:   r_looping   <= i_cfg_data[0];
                CFG_KEY_COUNT: r_key_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign acc_cmd = start && !busy;

    // key write broadcast
    always_comb begin
        wr.en             = acc_cmd && (i_cmd.opcode == OP_WRITE);
        wr.idx            = i_cmd.key_index;
        wr.key.time_value = i_cmd.time_value;
        wr.key.val_x      = i_cmd.value_x;
        wr.key.val_y      = i_cmd.value_y;
        wr.key.val_z      = i_cmd.value_z;
    end

    // keys in use
    logic [USED_W-1:0] kc_ext, kc_cap, used_calc;
    always_comb begin
        kc_ext    = USED_W'(r_key_count);
        kc_cap    = (kc_ext > USED_W'(MAX_KEYS)) ? USED_W'(MAX_KEYS) : kc_ext;
        used_calc = (r_looping && (kc_cap != '0)) ? kc_cap - 1'b1 : kc_cap;
    end

    // ------------------------------------------------------------------
    // cell chain; the token enters with only its valid bit set
    assign toks[0] = {r_launch, {($bits(t_tok) - 1){1'b0}}};

    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        kts_cell #(
            .CELL_IDX (g),
            .USED_W   (USED_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr       (wr),
            .i_qtime    (r_t),
            .i_used     (r_used),
            .i_prev_key (keys[(g == 0) ? 0 : g - 1]),
            .i_tok      (toks[g]),
            .o_key      (keys[g]),
            .o_tok      (toks[g+1])
        );
    end

    // ------------------------------------------------------------------
    // factor setup
    logic signed [TIME_W:0] num, den;
    logic [TIME_W:0]        an, ad;
    logic                   sat, zero_den;
    always_comb begin
        num      = signed'({1'b0, r_t}) - signed'({1'b0, r_lk.time_value});
        den      = signed'({1'b0, r_rk.time_value}) - signed'({1'b0, r_lk.time_value});
        an       = num[TIME_W] ? unsigned'(-num) : unsigned'(num);
        ad       = den[TIME_W] ? unsigned'(-den) : unsigned'(den);
        sat      = {2'b00, an} >= {ad, 2'b00};
        zero_den = (r_rk.time_value == r_lk.time_value);
    end

    // divider step: one quotient bit per cycle
    logic                    ge;
    logic [REM_W-1:0]        div_rem;
    logic [FAC_W-1:0]        q_next;
    logic signed [FAC_W-1:0] f_div;
    always_comb begin
        ge      = {1'b0, r_rem} >= r_dsh;
        div_rem = ge ? r_rem - r_dsh[REM_W-1:0] : r_rem;
        q_next  = {r_q[FAC_W-2:0], ge};
        if (r_neg) begin
            f_div = (q_next > FAC_W'(65536)) ? FAC_MIN : -signed'(q_next);
        end else begin
            f_div = q_next[FAC_W-1] ? FAC_MAX : signed'(q_next);
        end
    end

    // mixer: each component takes a multiply phase and then a mix phase
    logic signed [VAL_W-1:0]  v0, v1;
    logic signed [VAL_W:0]    diff;
    logic signed [SUM_W-1:0]  sum;
    logic signed [VAL_W-1:0]  mixed;
    always_comb begin
        case (r_comp)
            2'd0: begin
                v0 = r_lk.val_x;
                v1 = r_rk.val_x;
            end
            2'd1: begin
                v0 = r_lk.val_y;
                v1 = r_rk.val_y;
            end
            default: begin
                v0 = r_lk.val_z;
                v1 = r_rk.val_z;
            end
        endcase
        diff = {v1[VAL_W-1], v1} - {v0[VAL_W-1], v0};
        sum  = SUM_W'(v0) + SUM_W'(r_prod >>> 16);
        if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
            mixed = 32'sh7FFF_FFFF;
        end else if (sum < -SUM_W'(33'sh0_8000_0000)) begin
            mixed = 32'sh8000_0000;
        end else begin
            mixed = VAL_W'(sum);
        end
    end

    // ------------------------------------------------------------------
    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc_cmd && (i_cmd.opcode == OP_SAMPLE)) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (toks[MAX_KEYS].vld) begin
                    n_state = toks[MAX_KEYS].found ? ST_SETUP : ST_IDLE;
                end
            end
            ST_SETUP: begin
                n_state = (zero_den || sat) ? ST_MIX : ST_DIV;
            end
            ST_DIV: begin
                if (r_step == 5'(FAC_W - 1)) n_state = ST_MIX;
            end
            ST_MIX: begin
                if (r_phase && (r_comp == 2'd2)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch  <= 1'b0;
            r_res_vld <= 1'b0;
            r_phase   <= 1'b0;
            r_comp    <= 2'd0;
            r_step    <= 5'd0;
        end else begin
            r_launch  <= acc_cmd && (i_cmd.opcode == OP_SAMPLE);
            // strobe: write done, no match, or last component mixed
            r_res_vld <= (acc_cmd && (i_cmd.opcode == OP_WRITE))
                         || ((r_state == ST_WALK) && toks[MAX_KEYS].vld
                             && !toks[MAX_KEYS].found)
                         || ((r_state == ST_MIX) && r_phase && (r_comp == 2'd2));
            if (r_state == ST_SETUP) begin
                r_step  <= 5'd0;
                r_comp  <= 2'd0;
                r_phase <= 1'b0;
            end
            if (r_state == ST_DIV) r_step <= r_step + 5'd1;
            if (r_state == ST_MIX) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_comp <= r_comp + 2'd1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (acc_cmd) begin
            r_t    <= i_cmd.time_value;
            r_used <= used_calc;
            if (i_cmd.opcode == OP_WRITE) r_res <= '0;
        end
        if ((r_state == ST_WALK) && toks[MAX_KEYS].vld) begin
            r_seg <= toks[MAX_KEYS].seg;
            r_lk  <= toks[MAX_KEYS].lk;
            r_rk  <= toks[MAX_KEYS].rk;
            if (!toks[MAX_KEYS].found) begin
                r_res.out_x         <= keys[0].val_x;
                r_res.out_y         <= keys[0].val_y;
                r_res.out_z         <= keys[0].val_z;
                r_res.segment       <= '0;
                r_res.segment_found <= 1'b0;
            end
        end
        if (r_state == ST_SETUP) begin
            r_neg <= num[TIME_W] ^ den[TIME_W];
            r_rem <= {an, 16'd0};
            r_dsh <= {ad, 17'd0};
            r_q   <= '0;
            if (zero_den) begin
                r_f <= '0;
            end else if (sat) begin
                r_f <= (num[TIME_W] ^ den[TIME_W]) ? FAC_MIN : FAC_MAX;
            end
        end
        if (r_state == ST_DIV) begin
            r_rem <= div_rem;
            r_dsh <= r_dsh >> 1;
            r_q   <= q_next;
            if (r_step == 5'(FAC_W - 1)) r_f <= f_div;
        end
        if (r_state == ST_MIX) begin
            if (!r_phase) begin
                r_prod <= diff * r_f;
            end else begin
                case (r_comp)
                    2'd0:    r_res.out_x <= mixed;
                    2'd1:    r_res.out_y <= mixed;
                    default: r_res.out_z <= mixed;
                endcase
                r_res.segment       <= r_seg;
                r_res.segment_found <= 1'b1;
            end
        end
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

endmodule
